// ===== hdl/float_mat4_vec4_transform_top_assert.svh =====
// assertion macros for the float matrix transform block
`ifndef FLOAT_MAT4_VEC4_TRANSFORM_TOP_ASSERT_SVH
`define FLOAT_MAT4_VEC4_TRANSFORM_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FMV_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication checked on every clock edge outside reset
`define FMV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/fmv_pkg.sv =====
// package with float helper functions for the matrix transform
`default_nettype none
package fmv_pkg;
	localparam logic [31:0] QNAN = 32'h7FC00000;
	localparam logic [31:0] INF = 32'h7F800000;
	localparam int NUM_REGS = 8;

	function automatic logic f_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic f_inf(input logic [31:0] a);
		return a[30:0] == INF[30:0];
	endfunction

	function automatic logic f_zero(input logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	// value = sig * 2^(exp2); sig below 2^62, nonzero
	function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] exp2,
			input logic [61:0] sig);
		logic [5:0] p;
		logic signed [12:0] e;
		logic signed [12:0] sh;
		logic [61:0] m;
		logic [61:0] rem;
		logic [61:0] half;
		logic [63:0] enc;
		p = 6'd0;
		for (int i = 0; i < 62; i++) begin
			if (sig[i]) begin
				p = 6'(i);
			end
		end
		e = 13'(exp2) + 13'(p) + 13'sd127;
		sh = 13'(p) - 13'sd23;
		if (e < 13'sd1) begin
			sh = sh + 13'sd1 - e;
			e = 13'sd0;
		end else begin
			e = e - 13'sd1;
		end
		if (sh <= 13'sd0) begin
			m = sig << (-sh);
		end else if (sh >= 13'sd62) begin
			m = 62'd0;
		end else begin
			half = 62'd1 << (sh - 13'sd1);
			rem = sig & ((62'd1 << sh) - 62'd1);
			m = sig >> sh;
			if (rem > half || (rem == half && m[0])) begin
				m = m + 62'd1;
			end
		end
		enc = 64'({e[11:0], 23'd0}) + 64'(m);
		if (e >= 13'sd255 || enc >= 64'(INF)) begin
			return {sgn, INF[30:0]};
		end
		return {sgn, enc[30:0]};
	endfunction
endpackage
`default_nettype wire

// ===== hdl/fmv_fmul.sv =====
// two-stage single-precision multiplier
`default_nettype none
module fmv_fmul import fmv_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	output logic [31:0] y
);
	logic [47:0] prod_s1;
	logic signed [11:0] exp_s1;
	logic sgn_s1;
	logic spec_s1;
	logic [31:0] spec_val_s1;
	logic [23:0] ma;
	logic [23:0] mb;

	assign ma = {a[30:23] != 8'd0, a[22:0]};
	assign mb = {b[30:23] != 8'd0, b[22:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= a[31] ^ b[31];
			prod_s1 <= ma * mb;
			exp_s1 <= 12'($signed({1'b0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}))
				+ 12'($signed({1'b0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]})) - 12'sd300;
			spec_s1 <= 1'b1;
			if (f_nan(a) || f_nan(b)) begin
				spec_val_s1 <= QNAN;
			end else if (f_inf(a) || f_inf(b)) begin
				spec_val_s1 <= (f_zero(a) || f_zero(b)) ? QNAN : {a[31] ^ b[31], INF[30:0]};
			end else if (f_zero(a) || f_zero(b)) begin
				spec_val_s1 <= {a[31] ^ b[31], 31'd0};
			end else begin
				spec_s1 <= 1'b0;
				spec_val_s1 <= 32'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= spec_s1 ? spec_val_s1 : round_pack(sgn_s1, exp_s1, 62'(prod_s1));
		end
	end
endmodule
`default_nettype wire

// ===== hdl/fmv_fadd.sv =====
// two-stage single-precision adder
`default_nettype none
module fmv_fadd import fmv_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	output logic [31:0] y
);
	logic [23:0] ma;
	logic [23:0] mb;
	logic [8:0] ea;
	logic [8:0] eb;
	logic swap;
	logic [23:0] mbig;
	logic [23:0] msml;
	logic [8:0] ebig;
	logic [8:0] diff;
	logic [55:0] msml_al;
	logic [55:0] lost;
	logic sbig;
	logic ssml;
	logic [56:0] sum_s1;
	logic signed [11:0] exp_s1;
	logic sgn_s1;
	logic spec_s1;
	logic [31:0] spec_val_s1;

	always_comb begin
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		ea = {1'b0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]};
		eb = {1'b0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]};
		swap = (eb > ea) || (eb == ea && mb > ma);
		mbig = swap ? mb : ma;
		msml = swap ? ma : mb;
		ebig = swap ? eb : ea;
		sbig = swap ? b[31] : a[31];
		ssml = swap ? a[31] : b[31];
		diff = swap ? eb - ea : ea - eb;
		msml_al = {msml, 32'd0};
		lost = 56'd0;
		if (diff >= 9'd56) begin
			msml_al = 56'd1;
		end else if (diff != 9'd0) begin
			lost = msml_al & ((56'd1 << diff) - 56'd1);
			msml_al = (msml_al >> diff) | 56'(lost != 56'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= sbig;
			exp_s1 <= 12'($signed({3'b0, ebig})) - 12'sd182;
			sum_s1 <= (sbig == ssml) ? 57'({mbig, 32'd0}) + 57'(msml_al)
				: 57'({mbig, 32'd0}) - 57'(msml_al);
			spec_s1 <= 1'b1;
			if (f_nan(a) || f_nan(b)) begin
				spec_val_s1 <= QNAN;
			end else if (f_inf(a)) begin
				spec_val_s1 <= (f_inf(b) && a[31] != b[31]) ? QNAN : a;
			end else if (f_inf(b)) begin
				spec_val_s1 <= b;
			end else if (f_zero(a) && f_zero(b)) begin
				spec_val_s1 <= {a[31] & b[31], 31'd0};
			end else if (f_zero(a)) begin
				spec_val_s1 <= b;
			end else if (f_zero(b)) begin
				spec_val_s1 <= a;
			end else begin
				spec_s1 <= 1'b0;
				spec_val_s1 <= 32'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (spec_s1) begin
				y <= spec_val_s1;
			end else if (sum_s1 == 57'd0) begin
				y <= 32'd0;
			end else begin
				y <= round_pack(sgn_s1, exp_s1, 62'(sum_s1));
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/float_mat4_vec4_transform_top.sv =====
// 4x4 float matrix times float vector transform, top level
// path from input transfer to result: multiply, then three adds in a chain
// throughput: one vector per cycle while the output is not stalled, set by the fully pipelined multipliers and adders
// a stall holds the whole pipeline; a result waits in the last stage
// reset clears valid bits and the matrix registers to zero
`default_nettype none
module float_mat4_vec4_transform_top import fmv_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [127:0] s_axis_tdata, // vec_x, vec_y, vec_z, vec_w
	input wire logic s_axis_tuser, // func
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [127:0] m_axis_tdata, // res_x, res_y, res_z, res_w
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_data
);
`include "float_mat4_vec4_transform_top_assert.svh"
	localparam int DEPTH = 8;

	logic [63:0] mat_q [NUM_REGS];
	logic [DEPTH-1:0] vld_q;
	logic en;
	logic [31:0] elem [16];
	logic [31:0] mul_a [16];
	logic [31:0] mul_b [16];
	logic [31:0] prod [16];
	logic [31:0] sum1 [4];
	logic [31:0] sum2 [4];
	logic [31:0] sum3 [4];

	assign cfg_ready = 1'b1;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++) begin
				mat_q[k] <= 64'd0;
			end
			vld_q <= '0;
		end else begin
			if (cfg_valid) begin
				mat_q[cfg_index] <= cfg_data;
			end
			if (en) begin
				vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
			end
		end
	end

	genvar gi, gj;
	generate
		for (gi = 0; gi < 16; gi++) begin : g_elem
			assign elem[gi] = (gi % 2 == 1) ? mat_q[gi/2][63:32] : mat_q[gi/2][31:0];
		end
		for (gi = 0; gi < 4; gi++) begin : g_row
			logic [31:0] p2_q;
			logic [31:0] p3_q [2];
			logic [31:0] p3b_q [3];
			for (gj = 0; gj < 4; gj++) begin : g_col
				assign mul_a[gi*4+gj] = s_axis_tuser ? elem[gj*4+gi] : elem[gi*4+gj];
				assign mul_b[gi*4+gj] = s_axis_tdata[gj*32 +: 32];
				fmv_fmul u_mul (.clk(clk), .en(en), .a(mul_a[gi*4+gj]),
					.b(mul_b[gi*4+gj]), .y(prod[gi*4+gj]));
			end
			fmv_fadd u_add1 (.clk(clk), .en(en), .a(prod[gi*4]), .b(prod[gi*4+1]),
				.y(sum1[gi]));
			fmv_fadd u_add2 (.clk(clk), .en(en), .a(sum1[gi]), .b(p2_q), .y(sum2[gi]));
			fmv_fadd u_add3 (.clk(clk), .en(en), .a(sum2[gi]), .b(p3b_q[2]),
				.y(sum3[gi]));
			always_ff @(posedge clk) begin
				if (en) begin
					p3_q[0] <= prod[gi*4+2];
					p2_q <= p3_q[0];
					p3_q[1] <= prod[gi*4+3];
					p3b_q[0] <= p3_q[1];
					p3b_q[1] <= p3b_q[0];
					p3b_q[2] <= p3b_q[1];
				end
			end
			assign m_axis_tdata[gi*32 +: 32] = sum3[gi];
		end
	endgenerate

	`FMV_ASSERT_IMP(a_stall_hold, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`FMV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`FMV_ASSERT_NEXT(a_valid_flow, en && s_axis_tvalid, vld_q[0])
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench for the float matrix transform: predicts each result vector and checks it
`timescale 1ns / 100ps
`default_nettype none
module tb import fmv_pkg::*; ();

	localparam logic [31:0] QUIET_NAN = 32'h7FC00000;
	localparam logic [31:0] INF_BITS = 32'h7F800000;
	localparam int LATENCY = 8;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef enum logic {FUNC_ROWS = 1'b0, FUNC_COLS = 1'b1} func_t;

	typedef struct packed {
		logic [31:0] w;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} vec4_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	logic [63:0] mat_pairs [NUM_REGS];
	vec4_t expected_vecs [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit recv_hold = 1'b0;
	int hold_cycles = 0;
	int errors = 0;
	longint cycles = 0;

	float_mat4_vec4_transform_top i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic bit is_nan32(logic [31:0] a);
		return a[30:23] == 8'hFF && a[22:0] != 0;
	endfunction

	function automatic bit is_inf32(logic [31:0] a);
		return a[30:0] == INF_BITS[30:0];
	endfunction

	function automatic bit is_zero32(logic [31:0] a);
		return a[30:0] == 0;
	endfunction

	// value = sig * 2^scale, rounded to nearest even
	function automatic logic [31:0] pack_rounded(logic sgn, int scale, longint unsigned sig);
		int msb;
		int bexp;
		int sh;
		longint unsigned mant;
		longint unsigned rem;
		longint unsigned half;
		longint unsigned enc;
		msb = 0;
		for (int i = 0; i < 62; i++)
			if (sig[i]) msb = i;
		bexp = scale + msb + 127;
		sh = msb - 23;
		if (bexp < 1) begin
			sh += 1 - bexp;
			bexp = 0;
		end else begin
			bexp -= 1;
		end
		if (bexp >= 255) return {sgn, INF_BITS[30:0]};
		if (sh <= 0) begin
			mant = sig << (-sh);
		end else if (sh >= 63) begin
			mant = 0;
		end else begin
			rem = sig & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			mant = sig >> sh;
			if (rem > half || (rem == half && mant[0])) mant++;
		end
		enc = (longint'(bexp) << 23) + mant;
		if (enc >= INF_BITS) return {sgn, INF_BITS[30:0]};
		return {sgn, enc[30:0]};
	endfunction

	function automatic void split32(logic [31:0] a, output int ex, output longint unsigned sig);
		if (a[30:23] == 0) begin
			ex = 1;
			sig = a[22:0];
		end else begin
			ex = a[30:23];
			sig = {1'b1, a[22:0]};
		end
	endfunction

	function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
		logic sgn;
		int ea;
		int eb;
		longint unsigned ma;
		longint unsigned mb;
		sgn = a[31] ^ b[31];
		if (is_nan32(a) || is_nan32(b)) return QUIET_NAN;
		if (is_inf32(a) || is_inf32(b)) begin
			if (is_zero32(a) || is_zero32(b)) return QUIET_NAN;
			return {sgn, INF_BITS[30:0]};
		end
		if (is_zero32(a) || is_zero32(b)) return {sgn, 31'd0};
		split32(a, ea, ma);
		split32(b, eb, mb);
		return pack_rounded(sgn, ea + eb - 300, ma * mb);
	endfunction

	function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b);
		int ea;
		int eb;
		int diff;
		int te;
		longint unsigned ma;
		longint unsigned mb;
		longint unsigned tm;
		longint unsigned big;
		longint unsigned sml;
		logic sa;
		logic sb;
		logic ts;
		sa = a[31];
		sb = b[31];
		if (is_nan32(a) || is_nan32(b)) return QUIET_NAN;
		if (is_inf32(a)) begin
			if (is_inf32(b) && sa != sb) return QUIET_NAN;
			return a;
		end
		if (is_inf32(b)) return b;
		if (is_zero32(a) && is_zero32(b)) return {sa & sb, 31'd0};
		if (is_zero32(a)) return b;
		if (is_zero32(b)) return a;
		split32(a, ea, ma);
		split32(b, eb, mb);
		if (eb > ea || (eb == ea && mb > ma)) begin
			ts = sa; te = ea; tm = ma;
			sa = sb; ea = eb; ma = mb;
			sb = ts; eb = te; mb = tm;
		end
		diff = ea - eb;
		big = ma << 32;
		sml = mb << 32;
		if (diff >= 63) sml = 1;
		else if (diff > 0) sml = (sml >> diff) | ((sml & ((64'd1 << diff) - 1)) != 0);
		if (sa == sb) return pack_rounded(sa, ea - 182, big + sml);
		if (big == sml) return 32'd0;
		return pack_rounded(sa, ea - 182, big - sml);
	endfunction

	function automatic vec4_t transform_vec(func_t fn, vec4_t v);
		logic [31:0] comp [4];
		logic [31:0] res [4];
		logic [31:0] elem;
		logic [31:0] prod;
		int k;
		comp = '{v.x, v.y, v.z, v.w};
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				k = (fn == FUNC_COLS) ? j * 4 + i : i * 4 + j;
				elem = k[0] ? mat_pairs[k >> 1][63:32] : mat_pairs[k >> 1][31:0];
				prod = mul32(elem, comp[j]);
				res[i] = (j == 0) ? prod : add32(res[i], prod);
			end
		end
		return '{w: res[3], z: res[2], y: res[1], x: res[0]};
	endfunction

	// receiver side: random stall plus a long hold when asked
	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
		if (recv_hold && hold_cycles <= 1) recv_hold <= 1'b0;
		m_axis_tready <= !(recv_hold && hold_cycles > 1) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		vec4_t got;
		vec4_t exp_v;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_vecs.size() == 0) begin
				$error("result transfer with nothing expected: %h", got);
				errors++;
			end else begin
				exp_v = expected_vecs.pop_front();
				if (got.x !== exp_v.x) begin $error("res_x exp %h got %h", exp_v.x, got.x); errors++; end
				if (got.y !== exp_v.y) begin $error("res_y exp %h got %h", exp_v.y, got.y); errors++; end
				if (got.z !== exp_v.z) begin $error("res_z exp %h got %h", exp_v.z, got.z); errors++; end
				if (got.w !== exp_v.w) begin $error("res_w exp %h got %h", exp_v.w, got.w); errors++; end
			end
		end
	end

	task automatic send_vec(func_t fn, vec4_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tuser <= fn;
		do @(posedge clk); while (!s_axis_tready);
		expected_vecs.push_back(transform_vec(fn, v));
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_vecs.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		mat_pairs[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_float();
		case ($urandom_range(9))
			0: return {1'($urandom), 8'hFF, 23'($urandom_range(1)) ? 23'($urandom) : 23'd0};
			1: return {1'($urandom), 8'h00, 23'($urandom)};
			2: return {1'($urandom), 31'd0};
			3: return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
			4: return {1'($urandom), 8'($urandom_range(1, 30)), 23'($urandom)};
			5: return $urandom;
			default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
		endcase
	endfunction

	function automatic vec4_t rand_vec();
		return '{w: rand_float(), z: rand_float(), y: rand_float(), x: rand_float()};
	endfunction

	task automatic load_matrix(int style);
		logic [31:0] lo;
		logic [31:0] hi;
		for (int r = 0; r < NUM_REGS; r++) begin
			case (style)
				0: begin lo = 32'h3F800000 * (r % 2 == 0); hi = 32'h3F800000 * (r % 2 == 0); end
				1: begin lo = 32'h7F7FFFFF; hi = 32'hFF7FFFFF; end
				2: begin lo = 32'h00000001; hi = 32'h807FFFFF; end
				3: begin lo = '1; hi = '1; end
				default: begin lo = rand_float(); hi = rand_float(); end
			endcase
			write_reg(r, {hi, lo});
		end
	endtask

	task automatic test_directed;
		// a pattern of ones and zeros, then extremes, then special values
		load_matrix(0);
		send_vec(FUNC_ROWS, '{w: 32'h3F800000, z: 32'h40000000, y: 32'hC0400000, x: 32'h40800000});
		send_vec(FUNC_COLS, '{w: 32'h3F800000, z: 32'h40000000, y: 32'hC0400000, x: 32'h40800000});
		send_vec(FUNC_ROWS, '{w: 32'h7FFFFFFF, z: 32'h7F800000, y: 32'h80000000, x: 32'h00000000});
		send_vec(FUNC_COLS, '{w: 32'hFFFFFFFF, z: 32'hFF800000, y: 32'h00000001, x: 32'h807FFFFF});
		drain();
		load_matrix(1);
		send_vec(FUNC_ROWS, '{w: 32'h7F7FFFFF, z: 32'h7F7FFFFF, y: 32'h7F7FFFFF, x: 32'h7F7FFFFF});
		send_vec(FUNC_COLS, '{w: 32'h3F800000, z: 32'h3F800000, y: 32'h3F800000, x: 32'h3F800000});
		send_vec(FUNC_ROWS, '{w: 32'h00000000, z: 32'h80000000, y: 32'h00000000, x: 32'h80000000});
		drain();
		load_matrix(2);
		send_vec(FUNC_ROWS, '{w: 32'h3F000000, z: 32'h3F000000, y: 32'h3F000000, x: 32'h3F000000});
		send_vec(FUNC_COLS, '{w: 32'h00800000, z: 32'h00000001, y: 32'h4B000000, x: 32'h34000000});
		drain();
		load_matrix(3);
		send_vec(FUNC_ROWS, '{w: 32'h3F800000, z: 32'h3F800000, y: 32'h3F800000, x: 32'h3F800000});
		drain();
		for (int r = 0; r < NUM_REGS; r++) write_reg(r, '0);
		send_vec(FUNC_ROWS, '{w: 32'h80000000, z: 32'h80000000, y: 32'h80000000, x: 32'h80000000});
		send_vec(FUNC_COLS, '{w: 32'h7F800000, z: 32'h3F800000, y: 32'h3F800000, x: 32'h3F800000});
		drain();
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		load_matrix(4);
		for (int i = 0; i < n; i++) send_vec(func_t'($urandom_range(1)), rand_vec());
		drain();
	endtask

	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles <= 60;
		recv_hold <= 1'b1;
		for (int i = 0; i < 40; i++) send_vec(func_t'($urandom_range(1)), rand_vec());
		drain();
		for (int i = 0; i < 10; i++) send_vec(func_t'($urandom_range(1)), rand_vec());
		drain();
	endtask

	initial begin
		for (int r = 0; r < NUM_REGS; r++) mat_pairs[r] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(450, 0, 0);
		test_random(450, 50, 0);
		test_random(450, 0, 50);
		test_random(400, 38, 38);
		test_backpressure();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/fmv_pkg.sv
hdl/fmv_fmul.sv
hdl/fmv_fadd.sv
hdl/float_mat4_vec4_transform_top.sv
test/tb.sv
